/* design/sps_pkg.sv */
package sps_pkg;

    // Default sizes of the sieve
    localparam int SPS_MAX_DIVISORS = 16;
    localparam int SPS_VALUE_WIDTH  = 16;

endpackage

/* design/sps_if.sv */
// Input channel: candidate value and start flag
interface sps_in_if #(
    parameter int VALUE_WIDTH = sps_pkg::SPS_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   start_new;

    modport source (output valid, input ready, output value, output start_new);
    modport sink   (input valid, output ready, input value, input start_new);
endinterface

// Result channel: surviving prime and table-full flag
interface sps_out_if #(
    parameter int VALUE_WIDTH = sps_pkg::SPS_VALUE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] prime;
    logic                   overflow;

    modport source (output valid, input ready, output prime, output overflow);
    modport sink   (input valid, output ready, input prime, input overflow);
endinterface

/* design/streaming_prime_sieve_unit.sv */
// Streaming trial-division prime sieve. Each accepted item carries a value and a
// start flag; the flag empties the divisor table before the value is handled.
// The value is tested against every stored divisor with one shared bit-serial
// (restoring) remainder unit; each divisor takes a memory fetch, a load, a
// division over all VALUE_WIDTH bits of the value and a check. The test stops
// at the first divisor that divides the value; a prime is tested against all
// stored ones. Values 0 and 1 give no result. A value that survives is sent
// out as a prime and appended to the table; when the table already holds
// MAX_DIVISORS entries it is still sent, with overflow set, and not stored.
// i_in.ready is high only while no item is in progress; a finished result sits
// in the output register, so the next item may be taken while it waits on
// o_res.ready.
module streaming_prime_sieve_unit #(
    parameter int MAX_DIVISORS = sps_pkg::SPS_MAX_DIVISORS,
    parameter int VALUE_WIDTH  = sps_pkg::SPS_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sps_in_if.sink      i_in,
    sps_out_if.source   o_res
);
    import sps_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIVISORS + 1);
    localparam int IDX_W = (MAX_DIVISORS > 1) ? $clog2(MAX_DIVISORS) : 1;
    localparam int BIT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_LOAD  = 6'b000100,
        S_DIV   = 6'b001000,
        S_CHECK = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    // Divisor table, one write and one registered read port
    logic [VALUE_WIDTH-1:0] r_mem [MAX_DIVISORS];
    logic [VALUE_WIDTH-1:0] r_div;

    t_state                 r_state,     n_state;
    logic [CNT_W-1:0]       r_count,     n_count;
    logic [CNT_W-1:0]       r_idx,       n_idx;
    logic [BIT_W-1:0]       r_bit,       n_bit;
    logic [VALUE_WIDTH-1:0] r_value,     n_value;
    logic [VALUE_WIDTH-1:0] r_shift,     n_shift;
    logic [VALUE_WIDTH-1:0] r_rem,       n_rem;
    logic                   r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0] r_prime,     n_prime;
    logic                   r_overflow,  n_overflow;

    logic                   w_wr_en;
    logic                   w_full;
    logic                   w_out_free;
    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH+1:0] w_diff;
    logic [CNT_W-1:0]       w_idx_next;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.prime    = r_prime;
    assign o_res.overflow = r_overflow;

    assign w_full     = (r_count >= CNT_W'(MAX_DIVISORS));
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_idx_next = r_idx + CNT_W'(1);

    // One restoring-division step: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_shift[VALUE_WIDTH-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_bit       = r_bit;
        n_value     = r_value;
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_out_valid = r_out_valid;
        n_prime     = r_prime;
        n_overflow  = r_overflow;
        w_wr_en     = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_value = i_in.value;
                    n_idx   = '0;
                    if (i_in.start_new) begin
                        n_count = '0;
                    end
                    if (i_in.value < VALUE_WIDTH'(2)) begin
                        n_state = S_IDLE;         // 0 and 1 are dropped
                    end else if (i_in.start_new || r_count == '0) begin
                        n_state = S_EMIT;         // empty table: prime at once
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;                 // read data lands in r_div
            end
            S_LOAD: begin
                n_rem   = '0;
                n_shift = r_value;
                n_bit   = BIT_W'(VALUE_WIDTH - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem   = w_diff[VALUE_WIDTH+1] ? w_trial[VALUE_WIDTH-1:0]
                                                : w_diff[VALUE_WIDTH-1:0];
                n_shift = {r_shift[VALUE_WIDTH-2:0], 1'b0};
                n_bit   = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_rem == '0) begin
                    n_state = S_IDLE;             // divisible: no result
                end else begin
                    n_idx = w_idx_next;
                    if (w_idx_next == r_count) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_prime     = r_value;
                    n_overflow  = w_full;
                    if (!w_full) begin
                        w_wr_en = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_bit      <= n_bit;
        r_value    <= n_value;
        r_shift    <= n_shift;
        r_rem      <= n_rem;
        r_prime    <= n_prime;
        r_overflow <= n_overflow;
    end

    // Table write on append, registered read at the running index
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= r_mem[r_idx[IDX_W-1:0]];
    end

endmodule

/* sim/streaming_prime_sieve_unit_tb.sv */
`timescale 1ns / 1ps

module streaming_prime_sieve_unit_tb;

    import sps_pkg::*;

    localparam int VALUE_W    = SPS_VALUE_WIDTH;
    localparam int TABLE_SIZE = SPS_MAX_DIVISORS;
    // Worst item: every stored divisor tested
    localparam int ITEM_CYCLES = 2 + TABLE_SIZE * (VALUE_W + 3);
    localparam int LONG_HOLD   = 1500;
    localparam int IDLE_LIMIT  = 4 * (LONG_HOLD + ITEM_CYCLES);

    typedef struct {
        logic [VALUE_W-1:0] prime;
        logic               overflow;
    } t_prime_result;

    typedef enum {
        SINK_OPEN,
        SINK_EVERY_THIRD,
        SINK_COIN,
        SINK_SPARSE
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    sps_in_if  #(.VALUE_WIDTH(VALUE_W)) in_if ();
    sps_out_if #(.VALUE_WIDTH(VALUE_W)) res_if ();

    streaming_prime_sieve_unit #(
        .MAX_DIVISORS(TABLE_SIZE),
        .VALUE_WIDTH (VALUE_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_res  (res_if)
    );

    // Predictor state: divisors found so far in the current stream
    logic [VALUE_W-1:0] known_divisors [TABLE_SIZE];
    int                 known_count;
    t_prime_result      expected_primes [$];

    int   mismatches;
    int   idle_cycles;
    int   burst_left;
    logic no_gaps;
    logic hold_req;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Trial division against the stored divisors; survivors become results
    function automatic void predict_prime(input logic [VALUE_W-1:0] v, input logic s);
        t_prime_result r;
        logic          full;
        if (s)
            known_count = 0;
        if (v < 2)
            return;
        for (int i = 0; i < known_count; i++) begin
            if (known_divisors[i] != '0 && (v % known_divisors[i]) == 0)
                return;
        end
        full = (known_count >= TABLE_SIZE);
        if (!full) begin
            known_divisors[known_count] = v;
            known_count++;
        end
        r.prime    = v;
        r.overflow = full;
        expected_primes.push_back(r);
    endfunction

    // Send one item; bursts of random length, random gaps between bursts
    task automatic push_candidate(input logic [VALUE_W-1:0] v, input logic s);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (no_gaps)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 40);
            else
                gap = $urandom_range(0, 3);
            if (gap > 0) begin
                @(negedge i_clk);
                in_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.value     <= v;
        in_if.start_new <= s;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_prime(v, s);
    endtask

    // Stop offering items and wait for every predicted prime to come out
    task automatic drain_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_primes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_edge_values();
        push_candidate(16'd2, 1'b1);
        push_candidate(16'd4, 1'b0);      // even, no result
        push_candidate(16'd0, 1'b0);      // below two, ignored
        push_candidate(16'd2, 1'b0);      // duplicate of a stored divisor
        push_candidate(16'hFFFF, 1'b0);
        push_candidate(16'd65521, 1'b0);  // largest 16-bit prime
        push_candidate(16'd1, 1'b1);      // clear, value ignored
        push_candidate(16'd4, 1'b0);      // table empty, so 4 survives
        push_candidate(16'd9, 1'b0);
        push_candidate(16'd7, 1'b0);      // descending order
        drain_results();
    endtask

    task automatic test_table_full();
        int first_primes [TABLE_SIZE] = '{2, 3, 5, 7, 11, 13, 17, 19,
                                          23, 29, 31, 37, 41, 43, 47, 53};
        for (int i = 0; i < TABLE_SIZE; i++)
            push_candidate(first_primes[i][VALUE_W-1:0], i == 0);
        push_candidate(16'd59, 1'b0);     // overflow, not stored
        push_candidate(16'd3481, 1'b0);   // 59*59 slips through with overflow
        push_candidate(16'd118, 1'b0);    // even, no result
        push_candidate(16'd65521, 1'b0);
        push_candidate(16'd4, 1'b1);      // clears the full table
        drain_results();
    endtask

    // Well-formed ascending runs with random content, mixed with noise
    task automatic test_ascending_runs(input int n_items);
        int                 sent;
        int                 len;
        int                 step;
        int                 pick;
        logic               clear_first;
        logic [VALUE_W-1:0] v;
        sent = 0;
        while (sent < n_items) begin
            v           = ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom) : VALUE_W'(2);
            len         = $urandom_range(8, 45);
            step        = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 7) : 1;
            clear_first = ($urandom_range(0, 7) != 0);
            for (int i = 0; i < len && sent < n_items; i++) begin
                pick = $urandom_range(0, 24);
                if (pick == 0)
                    push_candidate(VALUE_W'($urandom_range(0, 1)), 1'b0);
                else if (pick == 1)
                    push_candidate(VALUE_W'($urandom), 1'($urandom_range(0, 1)));
                else if (pick == 2)
                    push_candidate(v - VALUE_W'(step), 1'b0);  // one step back, a repeat once the run has begun
                else begin
                    push_candidate(v, clear_first && i == 0);
                    v = v + VALUE_W'(step);
                end
                sent++;
            end
        end
        drain_results();
    endtask

    task automatic test_descending_runs(input int n_items);
        int                 sent;
        int                 len;
        logic [VALUE_W-1:0] v;
        sent = 0;
        while (sent < n_items) begin
            v   = VALUE_W'($urandom_range(20, 65535));
            len = $urandom_range(6, 30);
            for (int i = 0; i < len && sent < n_items; i++) begin
                push_candidate(v, i == 0);
                v = v - VALUE_W'($urandom_range(1, 3));
                sent++;
            end
        end
        drain_results();
    endtask

    task automatic test_random_values(input int n_items);
        for (int i = 0; i < n_items; i++)
            push_candidate(VALUE_W'($urandom), $urandom_range(0, 15) == 0);
        drain_results();
    endtask

    // Result side blocked for a long time while items keep coming back to back
    task automatic test_backpressure();
        logic [VALUE_W-1:0] v;
        v        = VALUE_W'(2);
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (int i = 0; i < 30; i++) begin
            push_candidate(v, i == 0);
            v = v + VALUE_W'(1);
        end
        no_gaps = 1'b0;
        drain_results();
    endtask

    // Result sink: a shifting stall pattern, or one long hold on request
    initial begin : result_sink
        int         phase;
        t_sink_mode mode;
        phase        = 0;
        mode         = SINK_OPEN;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (phase == 0) begin
                    mode  = t_sink_mode'($urandom_range(0, 3));
                    phase = $urandom_range(20, 300);
                end
                phase--;
                case (mode)
                    SINK_OPEN:        res_if.ready <= 1'b1;
                    SINK_EVERY_THIRD: res_if.ready <= (phase % 3 != 0);
                    SINK_COIN:        res_if.ready <= 1'($urandom_range(0, 1));
                    default:          res_if.ready <= (phase % 8 < 2);
                endcase
            end
        end
    end

    // Result checker and stall watchdog
    always @(posedge i_clk) begin
        t_prime_result exp_r;
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;

            if (res_if.valid && res_if.ready) begin
                if (expected_primes.size() == 0) begin
                    $error("unexpected result: prime %0d overflow %0b",
                           res_if.prime, res_if.overflow);
                    mismatches++;
                end else begin
                    exp_r = expected_primes.pop_front();
                    if (res_if.prime !== exp_r.prime) begin
                        $error("prime: expected %0d, got %0d", exp_r.prime, res_if.prime);
                        mismatches++;
                    end
                    if (res_if.overflow !== exp_r.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               exp_r.overflow, res_if.overflow);
                        mismatches++;
                    end
                end
            end

            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        mismatches      = 0;
        idle_cycles     = 0;
        burst_left      = 0;
        no_gaps         = 1'b0;
        hold_req        = 1'b0;
        known_count     = 0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.value     = '0;
        in_if.start_new = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_values();
        test_table_full();
        test_ascending_runs(470);
        test_backpressure();
        test_descending_runs(120);
        test_random_values(200);

        // let any item that gives no result finish before the verdict
        repeat (2 * ITEM_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_primes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* streaming_prime_sieve_unit.f */
design/sps_pkg.sv
design/sps_if.sv
design/streaming_prime_sieve_unit.sv
sim/streaming_prime_sieve_unit_tb.sv
